// ===== design/psfp_pkg.sv =====
// shared types and constants of the prefix/suffix frame parser
`default_nettype none

package psfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned REG_W     = 35;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned LEN_LSB   = 32;
  localparam int unsigned MAX_SLOTS = 4;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned KIND_W    = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END         = 4'd8;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PREFIX = 2'd1,
    MODE_BODY   = 2'd2,
    MODE_SUFFIX = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    EV_BODY  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } event_e;

  typedef logic [REG_W-1:0] tag_reg_t;

endpackage

`default_nettype wire

// ===== design/prefix_suffix_frame_parser.sv =====
// top level of the prefix/suffix frame parser
//
// usage:
//   one byte enters per input item (data_byte_i, in_valid_i / in_stall_o).
//   up to NUM_HANDLERS handlers each own a prefix of 0..TAG_BYTES bytes and a
//   suffix of 1..TAG_BYTES bytes, written through the plain config port (cfg_we_i,
//   cfg_idx_i, cfg_data_i): indexes 0..3 are prefixes, 4..7 suffixes, others ignored.
//   an item gives zero or one result item (out_valid_o / out_stall_i): a body
//   byte, a frame completed or a frame aborted, tagged with the owning handler.
// timing:
//   the whole prefix/body/suffix update is one pass of byte compares between
//   the accepted byte and the result register, so a result shows in the cycle
//   after its item is accepted and an item can be accepted every cycle unless stalled.
//   the result register frees in the same cycle its item is taken, so the
//   input is only stalled while a result waits and the receiver stalls.
// reset:
//   rst_ni clears the parse state, the result valid and all tag registers.
`default_nettype none

module prefix_suffix_frame_parser #(
  parameter int unsigned NUM_HANDLERS = 4,
  parameter int unsigned TAG_BYTES    = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [psfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [psfp_pkg::REG_W-1:0]      cfg_data_i,
  // input items
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [psfp_pkg::BYTE_W-1:0]     data_byte_i,
  // result items
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [psfp_pkg::KIND_W-1:0]          event_kind_o,
  output logic [psfp_pkg::SLOT_W-1:0]          handler_index_o,
  output logic [psfp_pkg::BYTE_W-1:0]          body_byte_o
);

  // position counter holds 0..TAG_BYTES
  localparam int unsigned POS_W = (TAG_BYTES + 1 > 4) ? 3 : ((TAG_BYTES + 1 > 2) ? 2 : 1);
  localparam logic [psfp_pkg::LEN_W-1:0] MAX_LEN = psfp_pkg::LEN_W'(TAG_BYTES);

  // byte pos of a packed tag register
  function automatic logic [psfp_pkg::BYTE_W-1:0] tag_byte(
    input psfp_pkg::tag_reg_t r,
    input logic [1:0]         p
  );
    return r[{p, 3'b000} +: psfp_pkg::BYTE_W];
  endfunction

  // tag length limited to TAG_BYTES, and to at least one when min_one is set
  function automatic logic [POS_W-1:0] tag_len(
    input psfp_pkg::tag_reg_t r,
    input logic               min_one
  );
    logic [psfp_pkg::LEN_W-1:0] raw;
    raw = r[psfp_pkg::LEN_LSB +: psfp_pkg::LEN_W];
    if (raw > MAX_LEN) raw = MAX_LEN;
    if (min_one && raw == '0) raw = psfp_pkg::LEN_W'(1);
    return POS_W'(raw);
  endfunction

  // tag registers
  psfp_pkg::tag_reg_t prefix_q [psfp_pkg::MAX_SLOTS];
  psfp_pkg::tag_reg_t suffix_q [psfp_pkg::MAX_SLOTS];

  // parse state
  psfp_pkg::mode_e                mode_q, mode_d;
  logic [NUM_HANDLERS-1:0]        cand_q, cand_d;
  logic [POS_W-1:0]               pos_q, pos_d;
  logic [psfp_pkg::SLOT_W-1:0]    active_q, active_d;

  // result register
  logic                           out_valid_q, out_valid_d;
  psfp_pkg::event_e               kind_q, kind_d;
  logic [psfp_pkg::SLOT_W-1:0]    hidx_q, hidx_d;
  logic [psfp_pkg::BYTE_W-1:0]    body_q, body_d;

  logic in_accept;

  // input is held only while an unaccepted result would be overwritten
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < psfp_pkg::MAX_SLOTS; i++) begin
        prefix_q[i] <= '0;
        suffix_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < psfp_pkg::CFG_SUFFIX_BASE) begin
        prefix_q[cfg_idx_i[psfp_pkg::SLOT_W-1:0]] <= cfg_data_i;
      end else if (cfg_idx_i < psfp_pkg::CFG_END) begin
        suffix_q[cfg_idx_i[psfp_pkg::SLOT_W-1:0]] <= cfg_data_i;
      end
    end
  end

  // one pass: prefix narrowing, body forwarding, suffix matching
  always_comb begin
    logic [NUM_HANDLERS-1:0]     mask;
    logic [POS_W-1:0]            mpos;
    logic [NUM_HANDLERS-1:0]     next;
    logic                        found;
    logic [psfp_pkg::SLOT_W-1:0] win;
    logic [POS_W-1:0]            plen;
    logic [POS_W-1:0]            slen;
    logic [POS_W-1:0]            pos_inc;
    logic                        emit;
    psfp_pkg::tag_reg_t          sfx;

    mode_d   = mode_q;
    cand_d   = cand_q;
    pos_d    = pos_q;
    active_d = active_q;
    emit     = 1'b0;
    kind_d   = psfp_pkg::EV_BODY;
    body_d   = '0;

    sfx     = suffix_q[active_q];
    slen    = tag_len(sfx, 1'b1);
    pos_inc = POS_W'(pos_q + 1'b1);

    // idle starts from every handler at the first byte
    mask = (mode_q == psfp_pkg::MODE_IDLE) ? '1 : cand_q;
    mpos = (mode_q == psfp_pkg::MODE_IDLE) ? '0 : pos_q;

    next  = '0;
    found = 1'b0;
    win   = '0;
    for (int i = 0; i < NUM_HANDLERS; i++) begin
      plen = tag_len(prefix_q[i], 1'b0);
      next[i] = mask[i] && (plen > mpos) &&
                (tag_byte(prefix_q[i], 2'(mpos)) == data_byte_i);
      // lowest completing handler wins
      if (!found && next[i] && plen == POS_W'(mpos + 1'b1)) begin
        found = 1'b1;
        win   = psfp_pkg::SLOT_W'(i);
      end
    end

    if (in_accept) begin
      case (mode_q)
        psfp_pkg::MODE_IDLE, psfp_pkg::MODE_PREFIX: begin
          if (mode_q == psfp_pkg::MODE_PREFIX && pos_q >= POS_W'(TAG_BYTES)) begin
            mode_d = psfp_pkg::MODE_IDLE;
            cand_d = '0;
            pos_d  = '0;
          end else if (found) begin
            mode_d   = psfp_pkg::MODE_BODY;
            active_d = win;
            cand_d   = '0;
            pos_d    = '0;
          end else if (next != '0) begin
            mode_d = psfp_pkg::MODE_PREFIX;
            cand_d = next;
            pos_d  = POS_W'(mpos + 1'b1);
          end else begin
            // mismatching byte is dropped, not retried as a new prefix start
            mode_d = psfp_pkg::MODE_IDLE;
            cand_d = '0;
            pos_d  = '0;
          end
        end
        psfp_pkg::MODE_BODY: begin
          if (tag_byte(sfx, 2'b00) == data_byte_i) begin
            if (slen == POS_W'(1)) begin
              emit   = 1'b1;
              kind_d = psfp_pkg::EV_DONE;
              mode_d = psfp_pkg::MODE_IDLE;
              cand_d = '0;
              pos_d  = '0;
            end else begin
              mode_d = psfp_pkg::MODE_SUFFIX;
              pos_d  = POS_W'(1);
            end
          end else begin
            emit   = 1'b1;
            kind_d = psfp_pkg::EV_BODY;
            body_d = data_byte_i;
          end
        end
        psfp_pkg::MODE_SUFFIX: begin
          mode_d = psfp_pkg::MODE_IDLE;
          cand_d = '0;
          pos_d  = '0;
          if (pos_q >= slen || tag_byte(sfx, 2'(pos_q)) != data_byte_i) begin
            emit   = 1'b1;
            kind_d = psfp_pkg::EV_ABORT;
          end else if (pos_inc == slen) begin
            emit   = 1'b1;
            kind_d = psfp_pkg::EV_DONE;
          end else begin
            mode_d = psfp_pkg::MODE_SUFFIX;
            pos_d  = pos_inc;
          end
        end
        default: begin
          mode_d = psfp_pkg::MODE_IDLE;
        end
      endcase
    end

    // result tags the handler that owns the frame at this byte
    hidx_d = active_q;

    if (in_accept) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= psfp_pkg::MODE_IDLE;
      cand_q      <= '0;
      pos_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cand_q      <= cand_d;
      pos_q       <= pos_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only when a new result is produced
  always_ff @(posedge clk_i) begin
    if (in_accept && out_valid_d) begin
      kind_q <= kind_d;
      hidx_q <= hidx_d;
      body_q <= body_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign handler_index_o = hidx_q;
  assign body_byte_o     = body_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for the prefix/suffix frame parser
`timescale 1ns / 1ps

module tb;

  localparam int HANDLERS    = 4;
  localparam int TAGS        = 4;
  localparam int DIR_ROWS    = 25;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int DRAIN       = 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    psfp_pkg::event_e kind;
    logic [1:0]       slot;
    logic [7:0]       data;
  } frame_event_t;

  // one row of the directed byte sequence; typed rows carry their own result
  typedef struct packed {
    logic [7:0]   b;
    logic         typed;
    logic         want;
    frame_event_t ev;
  } byte_row_t;

  typedef enum int {SET_ONES, SET_ZERO, SET_ALPHA, SET_RAW} setting_e;

  localparam frame_event_t NO_EV = '{psfp_pkg::EV_BODY, 2'd0, 8'h00};

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [psfp_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  psfp_pkg::tag_reg_t             cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic [psfp_pkg::BYTE_W-1:0]    data_byte = '0;
  logic                           out_stall = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic [psfp_pkg::KIND_W-1:0]    event_kind;
  logic [psfp_pkg::SLOT_W-1:0]    handler_index;
  logic [psfp_pkg::BYTE_W-1:0]    body_byte;

  prefix_suffix_frame_parser #(
    .NUM_HANDLERS(HANDLERS),
    .TAG_BYTES   (TAGS)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_kind_o   (event_kind),
    .handler_index_o(handler_index),
    .body_byte_o    (body_byte)
  );

  always #5 clk = ~clk;

  // parser state as predicted by the testbench
  psfp_pkg::tag_reg_t prefix_tag [4];
  psfp_pkg::tag_reg_t suffix_tag [4];
  psfp_pkg::mode_e    parse_state = psfp_pkg::MODE_IDLE;
  logic [3:0]         live_slots = '0;
  int unsigned        tag_pos = 0;
  logic [1:0]         owner = '0;

  frame_event_t pending_events [$];
  int           mismatch_count = 0;
  int           phase_results = 0;
  int unsigned  cycle_count = 0;
  int           in_gap_pct = 0;
  int           out_stall_pct = 0;
  logic [7:0]   alphabet [4];

  function automatic int unsigned eff_len(psfp_pkg::tag_reg_t r, int unsigned floor_len);
    int unsigned n;
    n = 32'(r[psfp_pkg::LEN_LSB +: psfp_pkg::LEN_W]);
    if (n > TAGS) n = TAGS;
    if (n < floor_len) n = floor_len;
    return n;
  endfunction

  function automatic logic [7:0] tag_at(psfp_pkg::tag_reg_t r, int unsigned pos);
    return r[8*(pos%4) +: 8];
  endfunction

  // narrow the live prefixes by one byte, opening a frame on the lowest completed one
  function automatic void narrow_prefix(logic [3:0] mask, int unsigned pos, logic [7:0] b);
    logic [3:0] hits;
    bit         opened;
    hits = '0;
    opened = 1'b0;
    for (int i = 0; i < HANDLERS; i++)
      if (mask[i] && eff_len(prefix_tag[i], 0) > pos && tag_at(prefix_tag[i], pos) == b)
        hits[i] = 1'b1;
    for (int i = 0; i < HANDLERS; i++)
      if (!opened && hits[i] && eff_len(prefix_tag[i], 0) == pos + 1) begin
        owner = 2'(i);
        opened = 1'b1;
      end
    if (opened) begin
      parse_state = psfp_pkg::MODE_BODY;
      live_slots = '0;
      tag_pos = 0;
    end else if (hits != '0) begin
      parse_state = psfp_pkg::MODE_PREFIX;
      live_slots = hits;
      tag_pos = pos + 1;
    end else begin
      parse_state = psfp_pkg::MODE_IDLE;
      live_slots = '0;
      tag_pos = 0;
    end
  endfunction

  function automatic bit predict_frame_event(logic [7:0] b, output frame_event_t ev);
    int unsigned slen;
    slen = eff_len(suffix_tag[owner], 1);
    ev = NO_EV;
    case (parse_state)
      psfp_pkg::MODE_IDLE: begin
        narrow_prefix(4'hF, 0, b);
        return 1'b0;
      end
      psfp_pkg::MODE_PREFIX: begin
        if (tag_pos >= TAGS) begin
          parse_state = psfp_pkg::MODE_IDLE;
          live_slots = '0;
          tag_pos = 0;
        end else begin
          narrow_prefix(live_slots, tag_pos, b);
        end
        return 1'b0;
      end
      psfp_pkg::MODE_BODY: begin
        if (tag_at(suffix_tag[owner], 0) == b) begin
          if (slen == 1) begin
            ev = '{psfp_pkg::EV_DONE, owner, 8'h00};
            parse_state = psfp_pkg::MODE_IDLE;
            return 1'b1;
          end
          parse_state = psfp_pkg::MODE_SUFFIX;
          tag_pos = 1;
          return 1'b0;
        end
        ev = '{psfp_pkg::EV_BODY, owner, b};
        return 1'b1;
      end
      default: begin
        // suffix bytes are swallowed; any miss aborts the frame
        if (tag_pos >= slen || tag_at(suffix_tag[owner], tag_pos) != b) begin
          ev = '{psfp_pkg::EV_ABORT, owner, 8'h00};
          parse_state = psfp_pkg::MODE_IDLE;
          tag_pos = 0;
          return 1'b1;
        end
        tag_pos++;
        if (tag_pos == slen) begin
          ev = '{psfp_pkg::EV_DONE, owner, 8'h00};
          parse_state = psfp_pkg::MODE_IDLE;
          tag_pos = 0;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic psfp_pkg::tag_reg_t draw_tag(setting_e s);
    psfp_pkg::tag_reg_t r;
    logic [2:0]         n;
    case (s)
      SET_ONES: r = '1;
      SET_ZERO: r = '0;
      SET_RAW:  r = {3'($urandom_range(7)), 32'($urandom())};
      default: begin
        // short alphabet so that prefixes and suffixes overlap often
        n = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, TAGS));
        r = '0;
        r[psfp_pkg::LEN_LSB +: psfp_pkg::LEN_W] = n;
        for (int k = 0; k < TAGS; k++) r[8*k +: 8] = alphabet[$urandom_range(3)];
      end
    endcase
    return r;
  endfunction

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic write_reg(input logic [psfp_pkg::CFG_IDX_W-1:0] idx,
                           input psfp_pkg::tag_reg_t val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx < psfp_pkg::CFG_SUFFIX_BASE) prefix_tag[idx] = val;
    else if (idx < psfp_pkg::CFG_END) suffix_tag[idx - psfp_pkg::CFG_SUFFIX_BASE] = val;
  endtask

  task automatic send_item(input logic [7:0] b, input bit typed, input bit want,
                           input frame_event_t want_ev);
    frame_event_t ev;
    bit           got;
    while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = predict_frame_event(b, ev);
    if (typed) begin
      got = want;
      ev = want_ev;
    end
    if (got) begin
      pending_events.push_back(ev);
      phase_results++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // receiver back-pressure
  always @(posedge clk)
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);

  always @(posedge clk) begin : result_check
    frame_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        flag_error($sformatf("unexpected item kind %0d slot %0d byte %02h",
                             event_kind, handler_index, body_byte));
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind)
          flag_error($sformatf("event kind exp %0d got %0d", want.kind, event_kind));
        if (handler_index !== want.slot)
          flag_error($sformatf("handler exp %0d got %0d", want.slot, handler_index));
        if (body_byte !== want.data)
          flag_error($sformatf("body byte exp %02h got %02h", want.data, body_byte));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    byte_row_t    dir_rows [DIR_ROWS];
    setting_e     plan [NUM_PHASES];
    int           gap_mix [4];
    int           stall_mix [4];
    int           quota;
    int           sent;
    int           bad;
    int unsigned  h;
    int unsigned  plen;
    int unsigned  slen;
    int unsigned  nbody;
    bit           paused;
    logic [7:0]   b;

    gap_mix   = '{0, 55, 0, 22};
    stall_mix = '{0, 0, 55, 22};
    plan = '{SET_ONES, SET_ALPHA, SET_RAW, SET_ZERO, SET_ALPHA, SET_ALPHA, SET_RAW, SET_ALPHA};
    for (int i = 0; i < 4; i++) begin
      prefix_tag[i] = '0;
      suffix_tag[i] = '0;
    end

    // handler 0 "AB", handler 3 ff 00 80 7f; the rest shadow or stay unused
    dir_rows = '{
      '{8'h41, 1'b0, 1'b0, NO_EV},
      '{8'h42, 1'b0, 1'b0, NO_EV},                      // duplicate prefix, low slot wins
      '{8'h00, 1'b1, 1'b1, '{psfp_pkg::EV_BODY,  2'd0, 8'h00}},
      '{8'hFF, 1'b1, 1'b1, '{psfp_pkg::EV_BODY,  2'd0, 8'hFF}},
      '{8'h0D, 1'b1, 1'b1, '{psfp_pkg::EV_DONE,  2'd0, 8'h00}},  // zero-length suffix, one byte
      '{8'h41, 1'b0, 1'b0, NO_EV},
      '{8'hFF, 1'b1, 1'b0, NO_EV},                      // prefix miss, byte not retried
      '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'hFF, 1'b0, 1'b0, NO_EV},
      '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'h80, 1'b0, 1'b0, NO_EV},
      '{8'h7F, 1'b0, 1'b0, NO_EV},                      // clamped length opens handler 3
      '{8'h55, 1'b1, 1'b1, '{psfp_pkg::EV_BODY,  2'd3, 8'h55}},
      '{8'h0D, 1'b0, 1'b0, NO_EV},
      '{8'h0A, 1'b0, 1'b0, NO_EV},
      '{8'h0D, 1'b0, 1'b0, NO_EV},
      '{8'h0A, 1'b1, 1'b1, '{psfp_pkg::EV_DONE,  2'd3, 8'h00}},
      '{8'hFF, 1'b0, 1'b0, NO_EV},
      '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'h80, 1'b0, 1'b0, NO_EV},
      '{8'h7F, 1'b0, 1'b0, NO_EV},
      '{8'h0D, 1'b0, 1'b0, NO_EV},
      '{8'h0A, 1'b0, 1'b0, NO_EV},
      '{8'h0D, 1'b0, 1'b0, NO_EV},
      '{8'h0B, 1'b1, 1'b1, '{psfp_pkg::EV_ABORT, 2'd3, 8'h00}}   // miss on the last suffix byte
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(psfp_pkg::CFG_PREFIX_BASE,        {3'd2, 32'h0000_4241});
    write_reg(psfp_pkg::CFG_PREFIX_BASE + 4'd1, {3'd0, 32'h0000_0041});  // unused slot
    write_reg(psfp_pkg::CFG_PREFIX_BASE + 4'd2, {3'd2, 32'h0000_4241});
    write_reg(psfp_pkg::CFG_PREFIX_BASE + 4'd3, {3'd7, 32'h7F80_00FF});
    write_reg(psfp_pkg::CFG_SUFFIX_BASE,        {3'd0, 32'h0000_000D});
    write_reg(psfp_pkg::CFG_SUFFIX_BASE + 4'd1, {3'd1, 32'h0000_00AA});
    write_reg(psfp_pkg::CFG_SUFFIX_BASE + 4'd2, {3'd4, 32'hFFFF_FFFF});
    write_reg(psfp_pkg::CFG_SUFFIX_BASE + 4'd3, {3'd5, 32'h0A0D_0A0D});
    // indexes past the register list must be dropped
    write_reg(psfp_pkg::CFG_END, '1);
    write_reg('1, '1);
    cfg_we <= 1'b0;

    foreach (dir_rows[r])
      send_item(dir_rows[r].b, dir_rows[r].typed, dir_rows[r].want, dir_rows[r].ev);
    settle();
    repeat (DRAIN) @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_gap_pct = gap_mix[p % 4];
      out_stall_pct = stall_mix[p % 4];
      for (int k = 0; k < 4; k++) alphabet[k] = 8'($urandom());
      for (int i = 0; i < 4; i++) begin
        write_reg(psfp_pkg::CFG_PREFIX_BASE + 4'(i), draw_tag(plan[p]));
        write_reg(psfp_pkg::CFG_SUFFIX_BASE + 4'(i), draw_tag(plan[p]));
      end
      cfg_we <= 1'b0;

      quota = (plan[p] == SET_ZERO) ? 40 : PHASE_ITEMS;
      sent = 0;
      phase_results = 0;
      paused = 1'b0;
      while (sent < quota ||
             (plan[p] != SET_ZERO && phase_results < 40 && sent < 3 * quota)) begin
        if (!paused && sent >= quota / 2) begin
          // hold the sender until the receiver has drained everything
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(9) < 8) begin
          // well-formed frame with random body and an occasional broken suffix
          h = $urandom_range(HANDLERS - 1);
          plen = eff_len(prefix_tag[h], 0);
          for (int k = 0; k < plen; k++) begin
            send_item(tag_at(prefix_tag[h], k), 1'b0, 1'b0, NO_EV);
            sent++;
          end
          nbody = $urandom_range(12);
          for (int k = 0; k < nbody; k++) begin
            send_item(8'($urandom()), 1'b0, 1'b0, NO_EV);
            sent++;
          end
          slen = eff_len(suffix_tag[h], 1);
          bad = ($urandom_range(4) == 0) ? int'($urandom_range(slen - 1)) : -1;
          for (int k = 0; k < slen; k++) begin
            b = tag_at(suffix_tag[h], k);
            if (k == bad) b = b ^ 8'($urandom_range(1, 255));
            send_item(b, 1'b0, 1'b0, NO_EV);
            sent++;
          end
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_item(8'($urandom()), 1'b0, 1'b0, NO_EV);
            sent++;
          end
        end
      end
      settle();
      repeat (DRAIN) @(posedge clk);
    end

    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && pending_events.size() != 0; w++) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (pending_events.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_events.size()));

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/psfp_pkg.sv
design/prefix_suffix_frame_parser.sv
sim/tb.sv
